[sv/rvtd_pkg.sv]
// Shared constants, widths and the arctangent table for the vector turn pipeline.
// No dependencies; every other file imports this package.
package rvtd_pkg;

   localparam int COORD_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;
   localparam int TURN_WIDTH       = 15;
   localparam int GUARD_BASE       = 37;   // coordinates scale up by 2^(GUARD_BASE - width)
   localparam int DW               = 40;   // CORDIC x/y datapath
   localparam int ZW               = 34;   // angle accumulator, Q3.30
   localparam int ANG_WIDTH        = 17;   // heading, Q3.13
   localparam int DIFF_WIDTH       = 18;   // heading difference, Q4.13
   localparam int SPLIT            = 20;   // low half of a gain product
   localparam int PP_WIDTH         = 46;   // one partial product
   localparam int PW               = 66;   // full gain product

   localparam logic signed [ANG_WIDTH-1:0]  PI_Q13      = 17'sd25736;
   localparam logic signed [DIFF_WIDTH-1:0] PI_DIFF     = 18'sd25736;
   localparam logic signed [DIFF_WIDTH-1:0] TWO_PI_DIFF = 18'sd51472;
   localparam logic signed [ZW-1:0]         PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0]         HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [24:0]           INV_GAIN    = 25'sd10188014;

   localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
      34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
      34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
      34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127
   };

endpackage

[sv/rvtd_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on rvtd_pkg.
interface rvtd_req_if #(parameter int COORD_WIDTH = rvtd_pkg::COORD_WIDTH_DEF) ();
   import rvtd_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] current_x;
   logic signed [COORD_WIDTH-1:0] current_y;
   logic signed [COORD_WIDTH-1:0] target_x;
   logic signed [COORD_WIDTH-1:0] target_y;
   logic [TURN_WIDTH-1:0]         max_turn;

   modport source (output valid, current_x, current_y, target_x, target_y, max_turn,
                   input ready);
   modport sink   (input valid, current_x, current_y, target_x, target_y, max_turn,
                   output ready);
endinterface

interface rvtd_rsp_if #(parameter int COORD_WIDTH = rvtd_pkg::COORD_WIDTH_DEF) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] result_x;
   logic signed [COORD_WIDTH-1:0] result_y;

   modport source (output valid, result_x, result_y, input ready);
   modport sink   (input valid, result_x, result_y, output ready);
endinterface

[sv/rotate_vector_towards_direction_top.sv]
// Pipeline: heading lanes, rotation and gain scaling, then an output register; each
// CORDIC step chain has S = min(CORDIC_STEPS, 24) steps.
// Throughput: one word per cycle while the skid stage is empty; a one-word skid stage
// behind the output register catches the word that arrives while a response waits.
// Reset: synchronous, active high; clears all valid bits, data registers keep contents.
module rotate_vector_towards_direction_top #(
   parameter int CORDIC_STEPS = rvtd_pkg::CORDIC_STEPS_DEF,
   parameter int COORD_WIDTH  = rvtd_pkg::COORD_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   rvtd_req_if.sink   req_chan,
   rvtd_rsp_if.source rsp_chan
);
   import rvtd_pkg::*;

   logic                          en;
   logic                          h_valid, r_valid, s_valid;
   logic signed [ANG_WIDTH-1:0]   cur_head, tgt_head;
   logic signed [COORD_WIDTH-1:0] h_x, h_y, s_x, s_y;
   logic [TURN_WIDTH-1:0]         h_turn;
   logic signed [DW-1:0]          rot_x, rot_y;
   logic                          out_valid_ff, skid_valid_ff;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic                          out_free;

   // Advance the whole pipeline whenever the skid stage is empty.
   assign en       = !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   rvtd_heading #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_heading (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .cur_x     (req_chan.current_x),
      .cur_y     (req_chan.current_y),
      .tgt_x     (req_chan.target_x),
      .tgt_y     (req_chan.target_y),
      .turn      (req_chan.max_turn),
      .out_valid (h_valid),
      .cur_head  (cur_head),
      .tgt_head  (tgt_head),
      .cur_x_out (h_x),
      .cur_y_out (h_y),
      .turn_out  (h_turn)
   );

   rvtd_rotate #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (h_valid),
      .cur_head  (cur_head),
      .tgt_head  (tgt_head),
      .cur_x     (h_x),
      .cur_y     (h_y),
      .turn      (h_turn),
      .out_valid (r_valid),
      .rot_x     (rot_x),
      .rot_y     (rot_y)
   );

   rvtd_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid),
      .rot_x     (rot_x),
      .rot_y     (rot_y),
      .out_valid (s_valid),
      .res_x     (s_x),
      .res_y     (s_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // Drain the held word once the output frees up.
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_valid_ff <= s_valid;
      end else if (s_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
         end
      end else if (out_free) begin
         out_x_ff <= s_x;
         out_y_ff <= s_y;
      end else begin
         skid_x_ff <= s_x;
         skid_y_ff <= s_y;
      end
   end

   assign req_chan.ready    = en;
   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.result_x = out_x_ff;
   assign rsp_chan.result_y = out_y_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_stall_into_skid: assert property (@(posedge clock) disable iff (reset)
      (en && s_valid && out_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("stalled pipeline word not captured in skid");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_chan.ready) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid word not moved to output");
`endif

endmodule

[sv/rvtd_heading.sv]
// Two CORDIC vectoring lanes: headings of the current and target vectors in Q3.13.
// Depends on rvtd_pkg.
module rvtd_heading #(
   parameter int COORD_WIDTH  = rvtd_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = rvtd_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [COORD_WIDTH-1:0]           cur_x,
   input  logic signed [COORD_WIDTH-1:0]           cur_y,
   input  logic signed [COORD_WIDTH-1:0]           tgt_x,
   input  logic signed [COORD_WIDTH-1:0]           tgt_y,
   input  logic [rvtd_pkg::TURN_WIDTH-1:0]         turn,
   output logic                                    out_valid,
   output logic signed [rvtd_pkg::ANG_WIDTH-1:0]   cur_head,
   output logic signed [rvtd_pkg::ANG_WIDTH-1:0]   tgt_head,
   output logic signed [COORD_WIDTH-1:0]           cur_x_out,
   output logic signed [COORD_WIDTH-1:0]           cur_y_out,
   output logic [rvtd_pkg::TURN_WIDTH-1:0]         turn_out
);
   import rvtd_pkg::*;

   localparam int NS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int GUARD = GUARD_BASE - COORD_WIDTH;
   localparam int SW    = 2 * COORD_WIDTH + TURN_WIDTH;

   logic signed [DW-1:0]        x_ff    [2][NS+1];
   logic signed [DW-1:0]        y_ff    [2][NS+1];
   logic signed [ZW-1:0]        z_ff    [2][NS+1];
   logic                        axis_ff [2][NS+1];
   logic                        neg_ff  [2][NS+1];
   logic signed [ANG_WIDTH-1:0] head_ff [2];
   logic [SW-1:0]               side_ff [NS+1];
   logic [SW-1:0]               side_out_ff;
   logic [NS:0]                 valid_ff;
   logic                        out_valid_ff;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [COORD_WIDTH-1:0] vx, vy;
      logic signed [DW-1:0]          xs_in, ys_in;
      logic signed [ZW-1:0]          z_in, zr;

      assign vx = (l == 0) ? cur_x : tgt_x;
      assign vy = (l == 0) ? cur_y : tgt_y;

      // Fold the left half plane onto the right and preload +-pi.
      always_comb begin
         xs_in = DW'(vx) <<< GUARD;
         ys_in = DW'(vy) <<< GUARD;
         z_in  = '0;
         if (vx < 0) begin
            xs_in = -xs_in;
            ys_in = -ys_in;
            z_in  = (vy >= 0) ? PI_Q30 : -PI_Q30;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[l][0]    <= xs_in;
            y_ff[l][0]    <= ys_in;
            z_ff[l][0]    <= z_in;
            axis_ff[l][0] <= (vy == 0);
            neg_ff[l][0]  <= (vx < 0);
         end
      end

      for (genvar i = 0; i < NS; i++) begin : g_step
         always_ff @(posedge clock) begin
            if (en) begin
               if (y_ff[l][i] >= 0) begin
                  x_ff[l][i+1] <= x_ff[l][i] + (y_ff[l][i] >>> i);
                  y_ff[l][i+1] <= y_ff[l][i] - (x_ff[l][i] >>> i);
                  z_ff[l][i+1] <= z_ff[l][i] + ATAN_Q30[i];
               end else begin
                  x_ff[l][i+1] <= x_ff[l][i] - (y_ff[l][i] >>> i);
                  y_ff[l][i+1] <= y_ff[l][i] + (x_ff[l][i] >>> i);
                  z_ff[l][i+1] <= z_ff[l][i] - ATAN_Q30[i];
               end
               axis_ff[l][i+1] <= axis_ff[l][i];
               neg_ff[l][i+1]  <= neg_ff[l][i];
            end
         end
      end

      // Round Q3.30 half up to Q3.13; a vector on the x axis takes an exact heading.
      assign zr = z_ff[l][NS] + (ZW'(1) <<< 16);

      always_ff @(posedge clock) begin
         if (en) begin
            if (axis_ff[l][NS]) begin
               head_ff[l] <= neg_ff[l][NS] ? PI_Q13 : '0;
            end else begin
               head_ff[l] <= ANG_WIDTH'(zr >>> 17);
            end
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0]  <= {cur_x, cur_y, turn};
         side_out_ff <= side_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[NS-1:0], in_valid};
         out_valid_ff <= valid_ff[NS];
      end
   end

   assign out_valid = out_valid_ff;
   assign cur_head  = head_ff[0];
   assign tgt_head  = head_ff[1];
   assign cur_x_out = side_out_ff[SW-1 -: COORD_WIDTH];
   assign cur_y_out = side_out_ff[TURN_WIDTH +: COORD_WIDTH];
   assign turn_out  = side_out_ff[TURN_WIDTH-1:0];

endmodule

[sv/rvtd_rotate.sv]
// Heading difference, wrap and clamp, then a CORDIC rotation of the current vector.
// Depends on rvtd_pkg.
module rvtd_rotate #(
   parameter int COORD_WIDTH  = rvtd_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = rvtd_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [rvtd_pkg::ANG_WIDTH-1:0] cur_head,
   input  logic signed [rvtd_pkg::ANG_WIDTH-1:0] tgt_head,
   input  logic signed [COORD_WIDTH-1:0]         cur_x,
   input  logic signed [COORD_WIDTH-1:0]         cur_y,
   input  logic [rvtd_pkg::TURN_WIDTH-1:0]       turn,
   output logic                                  out_valid,
   output logic signed [rvtd_pkg::DW-1:0]        rot_x,
   output logic signed [rvtd_pkg::DW-1:0]        rot_y
);
   import rvtd_pkg::*;

   localparam int NS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int GUARD = GUARD_BASE - COORD_WIDTH;

   logic signed [DIFF_WIDTH-1:0]  diff, wrap_in, lim, clamp_in;
   logic signed [DIFF_WIDTH-1:0]  a_ang_ff, b_ang_ff;
   logic signed [COORD_WIDTH-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic [TURN_WIDTH-1:0]         a_turn_ff;
   logic                          a_valid_ff, b_valid_ff;
   logic signed [DW-1:0]          xs, ys, x_in, y_in;
   logic signed [ZW-1:0]          z0, z_in;
   logic signed [DW-1:0]          x_ff [NS+1];
   logic signed [DW-1:0]          y_ff [NS+1];
   logic signed [ZW-1:0]          z_ff [NS+1];
   logic [NS:0]                   valid_ff;

   // Wrap into [-pi, pi]; exactly +-pi stays.
   always_comb begin
      diff    = DIFF_WIDTH'(tgt_head) - DIFF_WIDTH'(cur_head);
      wrap_in = diff;
      if (diff > PI_DIFF) begin
         wrap_in = diff - TWO_PI_DIFF;
      end else if (diff < -PI_DIFF) begin
         wrap_in = diff + TWO_PI_DIFF;
      end
   end

   always_comb begin
      lim      = $signed(DIFF_WIDTH'(a_turn_ff));
      clamp_in = a_ang_ff;
      if (a_ang_ff > lim) begin
         clamp_in = lim;
      end else if (a_ang_ff < -lim) begin
         clamp_in = -lim;
      end
   end

   // Pre-turn by a quarter circle when the angle is past +-pi/2.
   always_comb begin
      xs   = DW'(b_x_ff) <<< GUARD;
      ys   = DW'(b_y_ff) <<< GUARD;
      z0   = ZW'(b_ang_ff) <<< 17;
      x_in = xs;
      y_in = ys;
      z_in = z0;
      if (z0 > HALF_PI_Q30) begin
         x_in = -ys;
         y_in = xs;
         z_in = z0 - HALF_PI_Q30;
      end else if (z0 < -HALF_PI_Q30) begin
         x_in = ys;
         y_in = -xs;
         z_in = z0 + HALF_PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ang_ff  <= wrap_in;
         a_x_ff    <= cur_x;
         a_y_ff    <= cur_y;
         a_turn_ff <= turn;
         b_ang_ff  <= clamp_in;
         b_x_ff    <= a_x_ff;
         b_y_ff    <= a_y_ff;
         x_ff[0]   <= x_in;
         y_ff[0]   <= y_in;
         z_ff[0]   <= z_in;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_Q30[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_Q30[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         valid_ff   <= '0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         valid_ff   <= {valid_ff[NS-1:0], b_valid_ff};
      end
   end

   assign out_valid = valid_ff[NS];
   assign rot_x     = x_ff[NS];
   assign rot_y     = y_ff[NS];

endmodule

[sv/rvtd_scale.sv]
// Gain correction by the converged 1/K, rounding and saturation to the coordinate range.
// Depends on rvtd_pkg.
module rvtd_scale #(
   parameter int COORD_WIDTH = rvtd_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [rvtd_pkg::DW-1:0] rot_x,
   input  logic signed [rvtd_pkg::DW-1:0] rot_y,
   output logic                           out_valid,
   output logic signed [COORD_WIDTH-1:0]  res_x,
   output logic signed [COORD_WIDTH-1:0]  res_y
);
   import rvtd_pkg::*;

   localparam int GUARD = GUARD_BASE - COORD_WIDTH;
   localparam int SHIFT = GUARD + 24;
   localparam logic signed [PW-1:0] RND    = PW'(1) <<< (SHIFT - 1);
   localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (COORD_WIDTH - 1)) - PW'(1);
   localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

   logic signed [PP_WIDTH-1:0]    lo_ff  [2];
   logic signed [PP_WIDTH-1:0]    hi_ff  [2];
   logic signed [PW-1:0]          sum_ff [2];
   logic signed [COORD_WIDTH-1:0] res_ff [2];
   logic [2:0]                    valid_ff;

   for (genvar c = 0; c < 2; c++) begin : g_coord
      logic signed [DW-1:0]          v;
      logic signed [SPLIT:0]         lo_part;
      logic signed [DW-SPLIT-1:0]    hi_part;
      logic signed [PW-1:0]          shifted;
      logic signed [COORD_WIDTH-1:0] sat;

      assign v       = (c == 0) ? rot_x : rot_y;
      assign lo_part = $signed({1'b0, v[SPLIT-1:0]});
      assign hi_part = v[DW-1:SPLIT];
      assign shifted = sum_ff[c] >>> SHIFT;

      always_comb begin
         if (shifted > SAT_HI) begin
            sat = SAT_HI[COORD_WIDTH-1:0];
         end else if (shifted < SAT_LO) begin
            sat = SAT_LO[COORD_WIDTH-1:0];
         end else begin
            sat = shifted[COORD_WIDTH-1:0];
         end
      end

      // Split the product into two narrow halves; recombine one stage later.
      always_ff @(posedge clock) begin
         if (en) begin
            lo_ff[c]  <= lo_part * INV_GAIN;
            hi_ff[c]  <= hi_part * INV_GAIN;
            sum_ff[c] <= (PW'(hi_ff[c]) <<< SPLIT) + PW'(lo_ff[c]) + RND;
            res_ff[c] <= sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[2];
   assign res_x     = res_ff[0];
   assign res_y     = res_ff[1];

endmodule
